[rtl/mscd_pkg.sv]
// ----------------------------------------------------------------------------
// Manchester SWO capture decoder package
// Payload structs for the capture and result channels, and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package mscd_pkg;

  localparam logic [7:0] TOLERANCE_RESET = 8'd5;

  typedef struct packed {
    logic [15:0] cycle_ticks;
    logic [15:0] mark_ticks;
    logic        rising_capture;
  } capture_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } result_t;

  typedef struct packed {
    logic capture;      // register the accepted capture event
    logic commit;       // apply the evaluated event to the decoder state
    logic load_result;  // move the current store byte into the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic flush_req;    // evaluated event flushes at least one whole byte
    logic last_index;   // byte being read is the final one of the flush
    logic result_busy;  // result register holds a request that is stalled
  } dp_status_t;

endpackage

[rtl/mscd_datapath.sv]
// ----------------------------------------------------------------------------
// Manchester SWO capture decoder datapath
// Holds the lock state, bit assembly, byte store and result register, and
// evaluates one registered capture event per commit.
// ----------------------------------------------------------------------------
module mscd_datapath import mscd_pkg::*; #(
  parameter int BUFFER_BITS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_data,
  input  capture_t   capture_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  logic       result_stall,
  output logic       result_valid,
  output result_t    result_data
);

  localparam int STORE_BYTES = (BUFFER_BITS + 7) / 8;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int NB_W        = $clog2(STORE_BYTES + 1);
  localparam int CNT_W       = $clog2(BUFFER_BITS + 1);
  localparam logic [CNT_W-1:0] BB_CNT = CNT_W'(BUFFER_BITS);

  logic [7:0]       tolerance;
  capture_t         cap;
  logic [15:0]      half_bit_time;
  logic             pending_bit;
  logic [CNT_W-1:0] bit_count;
  logic [7:0]       acc;
  logic [NB_W-1:0]  flush_n;
  logic [ADDR_W-1:0] rd_idx;
  logic [7:0]       store [STORE_BYTES];
  logic [7:0]       store_q;

  // Evaluation results.
  logic [15:0]      hb_next;
  logic             pend_next;
  logic [CNT_W-1:0] cnt_eff;
  logic [7:0]       acc_next;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]       wr_byte;
  logic             ev_flush;
  logic [NB_W-1:0]  ev_n;

  logic [15:0] cyc, mark, space, adj;
  logic [16:0] hb2, adj2;
  logic [17:0] hb3, adj4;
  logic        rising, lm, ls, p2;
  logic [2:0]  pos1, pos2;
  logic [7:0]  acc1, acc2;
  logic [CNT_W-1:0] cnt1;

  always_comb begin
    cyc    = cap.cycle_ticks;
    mark   = cap.mark_ticks;
    rising = cap.rising_capture;
    space  = cyc - mark;
    adj    = mark - {8'd0, tolerance};
    adj2   = {adj, 1'b0};
    adj4   = {adj, 2'b00};
    hb2    = {half_bit_time, 1'b0};
    hb3    = {1'b0, hb2} + {2'b00, half_bit_time};
    lm     = {1'b0, mark} >= hb2;
    ls     = {1'b0, space} >= hb2;
    pos1   = bit_count[2:0];
    acc1   = ((pos1 == 3'd0) ? 8'd0 : acc) | ({7'd0, pending_bit} << pos1);
    cnt1   = bit_count + CNT_W'(1);
    p2     = lm | pending_bit;
    pos2   = cnt1[2:0];
    acc2   = ((pos2 == 3'd0) ? 8'd0 : acc1) | ({7'd0, p2} << pos2);

    hb_next   = half_bit_time;
    pend_next = pending_bit;
    cnt_eff   = bit_count;
    acc_next  = acc;
    wr_en     = 1'b0;
    wr_addr   = ADDR_W'(bit_count >> 3);
    wr_byte   = acc1;
    ev_flush  = 1'b0;

    if (rising && cyc == 16'd0) begin
      // Empty rising capture: nothing changes.
    end else if (cyc <= mark || mark == 16'd0 ||
                 (half_bit_time != 16'd0 && mark < half_bit_time)) begin
      ev_flush = 1'b1;
    end else if (half_bit_time == 16'd0) begin
      // Lock when the cycle to adjusted mark ratio is two or three.
      if (rising && mark > {8'd0, tolerance} &&
          {1'b0, cyc} >= adj2 && {2'b00, cyc} < adj4) begin
        hb_next   = adj;
        pend_next = ~({1'b0, space} >= adj2);
      end
    end else begin
      acc_next = acc1;
      cnt_eff  = cnt1;
      if (pos1 == 3'd7) begin
        wr_en = 1'b1;
      end
      if ({2'b00, cyc} >= hb3) begin
        if (lm && pending_bit) begin
          ev_flush = 1'b1;
        end else begin
          if ((lm || !ls) && cnt1 < BB_CNT) begin
            acc_next = acc2;
            cnt_eff  = cnt1 + CNT_W'(1);
            if (pos2 == 3'd7) begin
              wr_en   = 1'b1;
              wr_addr = ADDR_W'(cnt1 >> 3);
              wr_byte = acc2;
            end
          end
          if (ls && !p2) begin
            ev_flush = 1'b1;
          end
          pend_next = p2 & ~ls;
          if ({2'b00, space} >= hb3) begin
            ev_flush = 1'b1;
          end
        end
      end
      if (cnt_eff >= BB_CNT) begin
        ev_flush = 1'b1;
      end
    end
    ev_n = NB_W'(cnt_eff >> 3);
  end

  assign status.flush_req   = ev_flush && (ev_n != '0);
  assign status.last_index  = (NB_W'(rd_idx) + NB_W'(1)) == flush_n;
  assign status.result_busy = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance     <= TOLERANCE_RESET;
      half_bit_time <= 16'd0;
      pending_bit   <= 1'b0;
      bit_count     <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tolerance <= cfg_data;
      end
      if (cmd.commit) begin
        pending_bit <= pend_next;
        if (ev_flush) begin
          half_bit_time <= 16'd0;
          bit_count     <= '0;
        end else begin
          half_bit_time <= hb_next;
          bit_count     <= cnt_eff;
        end
      end
      if (cmd.load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap <= capture_data;
    end
    if (cmd.commit) begin
      acc     <= acc_next;
      flush_n <= ev_n;
      rd_idx  <= '0;
    end else if (cmd.load_result) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
    if (cmd.load_result) begin
      result_data.data_byte <= store_q;
      result_data.last_byte <= status.last_index;
    end
  end

  // Byte store: one write port for completed bytes, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      store[wr_addr] <= wr_byte;
    end
    store_q <= store[rd_idx];
  end

`ifndef SYNTHESIS
  a_count_below_full: assert property (@(posedge clk) disable iff (rst)
    bit_count < BB_CNT)
    else $error("bit count reached the store size outside a flush");
  a_unlocked_empty: assert property (@(posedge clk) disable iff (rst)
    (half_bit_time == 16'd0) |-> (bit_count == '0))
    else $error("bits held while the decoder is unlocked");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> !(result_valid && result_stall))
    else $error("result register loaded over a stalled request");
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (NB_W'(rd_idx) < flush_n))
    else $error("flush read beyond the bytes held");
`endif

endmodule

[rtl/mscd_controller.sv]
// ----------------------------------------------------------------------------
// Manchester SWO capture decoder controller
// Sequences capture, evaluation and the byte-by-byte flush walk.
// ----------------------------------------------------------------------------
module mscd_controller import mscd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       capture_valid,
  output logic       capture_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0] state, state_next;

  assign capture_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (capture_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.commit = 1'b1;
        state_next = status.flush_req ? S_READ : S_IDLE;
      end
      S_READ: begin
        // Store read data becomes valid at the end of this cycle.
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!status.result_busy) begin
          cmd.load_result = 1'b1;
          state_next      = status.last_index ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/manchester_swo_capture_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Manchester SWO capture decoder
// Locks the half-bit time from a start bit and decodes Manchester bits from
// edge-timing capture events into bytes.
// ----------------------------------------------------------------------------
// A capture event is registered, then evaluated: while unlocked it may lock
// the half-bit time, once locked it commits up to two bits. An event that
// flushes whole bytes then reads them one by one through the single registered
// read port of the byte store, each waiting while the result side stalls; no
// capture is taken during a flush. The store needs no clearing after reset. The
// tolerance register is written through its own channel, which is always ready.
module manchester_swo_capture_decoder_unit import mscd_pkg::*; #(
  parameter int BUFFER_BITS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       capture_valid,
  output logic       capture_stall,
  input  capture_t   capture_data,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mscd_controller u_controller (
    .clk           (clk),
    .rst           (rst),
    .capture_valid (capture_valid),
    .capture_stall (capture_stall),
    .status        (status),
    .cmd           (cmd)
  );

  mscd_datapath #(
    .BUFFER_BITS (BUFFER_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .capture_data (capture_data),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_data  (result_data)
  );

endmodule

[tb/sv/manchester_swo_capture_decoder_unit_tb.sv]
// ----------------------------------------------------------------------------
// Manchester SWO capture decoder testbench
// Drives capture events into the decoder and checks every flushed byte
// against a cycle-free model of the lock, bit decode and flush behavior.
// A short table of directed events comes first, then random well-formed
// packets mixed with noise, under several tolerance settings and with
// random idling on both channels.
// ----------------------------------------------------------------------------
module manchester_swo_capture_decoder_unit_tb;
  import mscd_pkg::*;

  localparam int BUFFER_BITS = 128;
  localparam int STORE_BYTES = BUFFER_BITS / 8;
  localparam int PHASE_ITEMS = 105;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    capture_t cap;
    bit       typed;   // expectation written in the table, not predicted
    int       n;       // number of typed results, zero or one
    result_t  res;
  } vector_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [7:0] cfg_data = 8'd0;
  logic     capture_valid = 1'b0;
  logic     capture_stall;
  capture_t capture_data = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  result_t  result_data;

  // Decoder model state.
  logic [7:0]  tol = TOLERANCE_RESET;
  logic [15:0] half_bit = '0;
  bit          pend = 1'b0;
  int unsigned nbits = 0;
  logic [7:0]  store [STORE_BYTES];

  result_t flushed_bytes[$];
  result_t expected_bytes[$];
  vector_t dir_tab[$];

  int  errors = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  long_packets = 1'b0;

  manchester_swo_capture_decoder_unit #(.BUFFER_BITS(BUFFER_BITS)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .capture_valid(capture_valid),
    .capture_stall(capture_stall),
    .capture_data (capture_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("tb: failure");
    $finish;
  end

  function automatic void store_bit(bit v);
    int unsigned idx;
    int unsigned pos;
    idx = (nbits >> 3) % STORE_BYTES;
    pos = nbits & 7;
    if (pos == 0) store[idx] = 8'd0;
    store[idx][pos] = v;
    nbits++;
  endfunction

  function automatic void flush_store();
    int unsigned n;
    result_t r;
    n = nbits >> 3;
    if (n > STORE_BYTES) n = STORE_BYTES;
    for (int unsigned i = 0; i < n; i++) begin
      r.data_byte = store[i];
      r.last_byte = (i + 1 == n);
      flushed_bytes.push_back(r);
    end
    nbits = 0;
    half_bit = '0;
  endfunction

  // Applies one capture event to the model; returns 0 when the event is ignored.
  function automatic bit decode_capture(capture_t c);
    int unsigned cyc, mk, sp, hb, adj, ratio;
    bit long_mark, long_space;
    cyc = c.cycle_ticks;
    mk = c.mark_ticks;
    hb = half_bit;
    flushed_bytes.delete();
    if (c.rising_capture && cyc == 0) return 1'b0;
    if (cyc <= mk || mk == 0 || (hb != 0 && mk < hb)) begin
      flush_store();
      return 1'b1;
    end
    sp = cyc - mk;
    if (hb == 0) begin
      if (!c.rising_capture || mk <= tol) return 1'b0;
      adj = mk - tol;
      ratio = cyc / adj;
      if (ratio < 2 || ratio > 3) return 1'b0;
      half_bit = adj[15:0];
      pend = (sp >= 2 * adj) ? 1'b0 : 1'b1;
      return 1'b1;
    end
    store_bit(pend);
    if (cyc >= 3 * hb) begin
      long_mark = (mk >= 2 * hb);
      long_space = (sp >= 2 * hb);
      if (long_mark) begin
        if (pend) begin
          flush_store();
          return 1'b1;
        end
        pend = 1'b1;
      end
      if ((long_mark || !long_space) && nbits < BUFFER_BITS) store_bit(pend);
      if (long_space) begin
        if (!pend) begin
          flush_store();
          return 1'b1;
        end
        pend = 1'b0;
      end
      if (sp >= 3 * hb) begin
        flush_store();
        return 1'b1;
      end
    end
    if (nbits >= BUFFER_BITS) flush_store();
    return 1'b1;
  endfunction

  // Picks the next event from the decoder's current state: a start bit while
  // unlocked, otherwise a Manchester cell that mostly keeps the packet alive.
  function automatic capture_t next_capture();
    capture_t c;
    int unsigned k, hb, lo, hi, mk, sp, cyc;
    k = $urandom_range(99, 0);
    c.rising_capture = 1'($urandom_range(1, 0));
    if (!long_packets && k < 4) begin
      c.cycle_ticks = 16'($urandom);
      c.mark_ticks = 16'($urandom);
      return c;
    end
    if (half_bit == 0) begin
      hb = ($urandom_range(9, 0) == 0) ? $urandom_range(9000, 200) : $urandom_range(60, 4);
      lo = (tol + 2) / 3 + 1;
      if (hb < lo) hb = lo + $urandom_range(20, 0);
      mk = hb + tol;
      lo = (2 * hb > mk + 1) ? 2 * hb : mk + 1;
      hi = 4 * hb - 1;
      cyc = $urandom_range(hi, lo);
      c.rising_capture = (k >= 10);
    end else begin
      hb = half_bit;
      if (!long_packets && k < 7) begin
        // End of packet: a space of three to four half bits.
        mk = $urandom_range(2 * hb - 1, hb);
        sp = $urandom_range(4 * hb, 3 * hb);
      end else if (!long_packets && k < 9) begin
        // Mark shorter than the locked half bit.
        mk = $urandom_range(hb - 1, 1);
        sp = $urandom_range(3 * hb, 1);
      end else if (k % 3 == 0) begin
        mk = $urandom_range(2 * hb - 1, hb);
        sp = $urandom_range(3 * hb - 1 - mk, 1);
      end else if (k % 3 == 1) begin
        mk = $urandom_range(2 * hb - 1, hb + 1);
        sp = $urandom_range(2 * hb - 1, 3 * hb - mk);
      end else if (pend) begin
        mk = $urandom_range(2 * hb - 1, hb);
        sp = $urandom_range(3 * hb - 1, 2 * hb);
      end else begin
        mk = $urandom_range(3 * hb - 1, 2 * hb);
        sp = $urandom_range(2 * hb - 1, 3 * hb - mk);
      end
      cyc = mk + sp;
    end
    c.cycle_ticks = cyc[15:0];
    c.mark_ticks = mk[15:0];
    return c;
  endfunction

  // Offers one capture request and applies it to the model once accepted.
  task automatic send_capture(input capture_t c, input bit keep, output bit effective);
    if (!quiet && $urandom_range(3, 0) == 0) begin
      capture_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    capture_valid <= 1'b1;
    capture_data <= c;
    @(posedge clk);
    while (capture_stall) @(posedge clk);
    effective = decode_capture(c);
    if (keep) begin
      foreach (flushed_bytes[i]) expected_bytes.push_back(flushed_bytes[i]);
    end
  endtask

  task automatic set_tolerance(input logic [7:0] value);
    capture_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    // A last event that flushed nothing may still be in evaluation.
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tol = value;
  endtask

  function automatic vector_t make_row(int cyc, int mk, int rise, int typed, int n,
                                       int b);
    vector_t v;
    v.cap.cycle_ticks = cyc[15:0];
    v.cap.mark_ticks = mk[15:0];
    v.cap.rising_capture = rise[0];
    v.typed = typed[0];
    v.n = n;
    v.res.data_byte = b[7:0];
    v.res.last_byte = 1'b1;
    return v;
  endfunction

  // Result side: checks accepted requests and drives stall.
  initial begin
    int idle_left;
    result_t want;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result request: data_byte %0h last_byte %0b",
                 result_data.data_byte, result_data.last_byte);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (result_data.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, actual %0h", want.data_byte,
                   result_data.data_byte);
            errors++;
          end
          if (result_data.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, actual %0b", want.last_byte,
                   result_data.last_byte);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        idle_left = HOLD_CYCLES;
      end
      if (idle_left == 0 && !quiet && $urandom_range(5, 0) == 0)
        idle_left = $urandom_range(5, 1);
      if (quiet && idle_left < 6) idle_left = 0;
      if (idle_left > 0) begin
        result_stall <= 1'b1;
        idle_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    bit eff;
    int count;
    logic [7:0] tol_set [4];

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset tolerance of 5 applies to every row below.
    dir_tab.push_back(make_row(0, 0, 1, 1, 0, 0));            // empty rising capture
    dir_tab.push_back(make_row(65535, 65535, 1, 1, 0, 0));    // cycle not above mark
    dir_tab.push_back(make_row(100, 0, 1, 1, 0, 0));          // zero mark
    dir_tab.push_back(make_row(100, 30, 0, 1, 0, 0));         // unlocked, no rising flag
    dir_tab.push_back(make_row(100, 5, 1, 1, 0, 0));          // mark within tolerance
    dir_tab.push_back(make_row(100, 60, 1, 1, 0, 0));         // ratio too small
    dir_tab.push_back(make_row(65535, 6, 1, 1, 0, 0));        // ratio too large
    dir_tab.push_back(make_row(30, 15, 1, 1, 0, 0));          // lock, half bit of 10
    for (int i = 0; i < 8; i++) dir_tab.push_back(make_row(20, 10, i % 2, 1, 0, 0));
    dir_tab.push_back(make_row(20, 0, 1, 1, 1, 255));         // flush of one byte
    dir_tab.push_back(make_row(30, 15, 1, 0, 0, 0));
    dir_tab.push_back(make_row(30, 20, 1, 0, 0, 0));          // long mark after a one
    dir_tab.push_back(make_row(25, 15, 1, 0, 0, 0));
    dir_tab.push_back(make_row(30, 10, 0, 0, 0, 0));          // long space
    dir_tab.push_back(make_row(30, 20, 0, 0, 0, 0));          // long mark
    dir_tab.push_back(make_row(40, 10, 0, 0, 0, 0));          // stop space
    dir_tab.push_back(make_row(65535, 65534, 0, 0, 0, 0));
    dir_tab.push_back(make_row(30, 15, 1, 0, 0, 0));
    dir_tab.push_back(make_row(30, 9, 0, 0, 0, 0));           // mark below half bit

    foreach (dir_tab[i]) begin
      send_capture(dir_tab[i].cap, !dir_tab[i].typed, eff);
      if (dir_tab[i].typed && dir_tab[i].n == 1) expected_bytes.push_back(dir_tab[i].res);
    end

    tol_set[0] = 8'd0;
    tol_set[1] = 8'd255;
    tol_set[2] = 8'($urandom_range(254, 1));
    tol_set[3] = TOLERANCE_RESET;
    for (int p = 0; p < 4; p++) begin
      set_tolerance(tol_set[p]);
      long_packets = (p == 2);
      quiet = (p == 3);
      if (p == 1) hold_req = 1'b1;
      count = 0;
      while (count < PHASE_ITEMS) begin
        send_capture(next_capture(), 1'b1, eff);
        if (eff) count++;
      end
    end

    capture_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
